[hw/rtl/kpl_pkg.sv]
// shared types and constants of the keypad password lock
package kpl_pkg;

  localparam logic [7:0] HDR_VALID   = 8'hAA;
  localparam logic [7:0] TYPE_KEYPAD = 8'h03;
  localparam logic [7:0] TYPE_CHANGE = 8'h04;
  localparam logic [7:0] LEN_KEYPAD  = 8'd1;
  localparam logic [7:0] LEN_CHANGE  = 8'd0;
  localparam logic [7:0] KEY_DELETE  = 8'd10;
  localparam logic [7:0] KEY_CONFIRM = 8'd12;

  localparam int unsigned CFG_DATA_W   = 24;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned BUF_IDX_W    = 4;
  localparam int unsigned TRIAL_W      = 4;
  localparam int unsigned FACTORY_W    = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIALS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTORY_PW = 1'b1;

  localparam logic [TRIAL_W-1:0]   MAX_TRIALS_RST = 4'd5;
  localparam logic [TRIAL_W-1:0]   TRIALS_SAT     = 4'd15;
  localparam logic [FACTORY_W-1:0] FACTORY_PW_RST = 24'h123456;

  typedef enum logic [3:0] {
    EV_UNRECOGNIZED = 4'd0,
    EV_DIGIT        = 4'd1,
    EV_DELETE       = 4'd2,
    EV_IGNORED      = 4'd3,
    EV_OK           = 4'd4,
    EV_WRONG        = 4'd5,
    EV_LOCKOUT      = 4'd6,
    EV_DISPLAY      = 4'd7,
    EV_CHANGE       = 4'd8,
    EV_REFUSED      = 4'd9,
    EV_STORED       = 4'd10
  } kpl_event_e;

  typedef struct packed {
    logic [7:0] header;
    logic [7:0] msg_type;
    logic [7:0] msg_length;
    logic [7:0] key_code;
  } kpl_pkt_t;

  typedef struct packed {
    kpl_event_e event_res;
    logic [7:0] display_value;
    logic [2:0] digit_count;
    logic       unlocked;
    logic       change_mode;
  } kpl_res_t;

  typedef struct packed {
    logic                 we;
    logic [BUF_IDX_W-1:0] idx;
    logic [3:0]           digit;
  } kpl_buf_wr_t;

endpackage

[hw/rtl/kpl_if.sv]
// valid/ready channel interfaces for keypad packets and results
interface kpl_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] header;
  logic [7:0] msg_type;
  logic [7:0] msg_length;
  logic [7:0] key_code;

  modport source (output valid, output header, output msg_type, output msg_length,
                  output key_code, input ready);
  modport sink (input valid, input header, input msg_type, input msg_length,
                input key_code, output ready);
endinterface

interface kpl_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_res;
  logic [7:0] display_value;
  logic [2:0] digit_count;
  logic       unlocked;
  logic       change_mode;

  modport source (output valid, output event_res, output display_value,
                  output digit_count, output unlocked, output change_mode, input ready);
  modport sink (input valid, input event_res, input display_value,
                input digit_count, input unlocked, input change_mode, output ready);
endinterface

[hw/rtl/kpl_entry.sv]
// entry digit buffer with packed read-out, first digit most significant
module kpl_entry
  import kpl_pkg::*;
#(
  parameter int unsigned PASSWORD_DIGITS = 6
) (
  input  logic                           clk_i,
  input  kpl_buf_wr_t                    wr_i,
  output logic [4*PASSWORD_DIGITS-1:0]   packed_o
);

  localparam int unsigned IdxW = (PASSWORD_DIGITS > 1) ? $clog2(PASSWORD_DIGITS) : 1;

  logic [3:0] digits_q [PASSWORD_DIGITS];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      digits_q[wr_i.idx[IdxW-1:0]] <= wr_i.digit;
    end
  end

  always_comb begin
    for (int i = 0; i < PASSWORD_DIGITS; i++) begin
      packed_o[4*(PASSWORD_DIGITS-1-i) +: 4] = digits_q[i];
    end
  end

endmodule

[hw/rtl/kpl_ctrl.sv]
// packet decode, mode flags, trial counter and password store
module kpl_ctrl
  import kpl_pkg::*;
#(
  parameter int unsigned PASSWORD_DIGITS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  kpl_pkt_t                      pkt_i,
  input  logic [TRIAL_W-1:0]            max_trials_i,
  input  logic [FACTORY_W-1:0]          factory_pw_i,
  input  logic [4*PASSWORD_DIGITS-1:0]  packed_i,
  output kpl_buf_wr_t                   buf_wr_o,
  output kpl_res_t                      res_o
);

  localparam int unsigned PwW  = 4 * PASSWORD_DIGITS;
  localparam int unsigned CntW = $clog2(PASSWORD_DIGITS + 1);
  localparam logic [CntW-1:0] NumDigits = CntW'(PASSWORD_DIGITS);

  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               unlocked_q, unlocked_d;
  logic               change_q, change_d;
  logic [TRIAL_W-1:0] trials_q, trials_d;
  logic [PwW-1:0]     stored_pw_q, stored_pw_d;
  logic               stored_valid_q, stored_valid_d;

  logic               is_key, is_change, is_digit;
  logic [TRIAL_W-1:0] trials_inc;
  logic [63:0]        factory_wide;
  logic [PwW-1:0]     ref_pw;
  kpl_event_e         ev;
  logic [7:0]         disp;
  logic               wr_en;

  assign is_key    = (pkt_i.header == HDR_VALID) && (pkt_i.msg_type == TYPE_KEYPAD) &&
                     (pkt_i.msg_length == LEN_KEYPAD);
  assign is_change = (pkt_i.header == HDR_VALID) && (pkt_i.msg_type == TYPE_CHANGE) &&
                     (pkt_i.msg_length == LEN_CHANGE);
  assign is_digit  = pkt_i.key_code inside {[8'd1:8'd9]};

  assign trials_inc   = (trials_q == TRIALS_SAT) ? TRIALS_SAT : trials_q + TRIAL_W'(1);
  assign factory_wide = 64'(factory_pw_i);
  assign ref_pw       = stored_valid_q ? stored_pw_q : factory_wide[PwW-1:0];

  always_comb begin
    cnt_d          = cnt_q;
    unlocked_d     = unlocked_q;
    change_d       = change_q;
    trials_d       = trials_q;
    stored_pw_d    = stored_pw_q;
    stored_valid_d = stored_valid_q;
    ev             = EV_UNRECOGNIZED;
    disp           = 8'd0;
    wr_en          = 1'b0;
    if (is_key) begin
      if (change_q || !unlocked_q) begin
        if (is_digit) begin
          if (cnt_q < NumDigits) begin
            wr_en = 1'b1;
            cnt_d = cnt_q + CntW'(1);
            ev    = EV_DIGIT;
          end else begin
            ev = EV_IGNORED;
          end
        end else if (pkt_i.key_code == KEY_DELETE) begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - CntW'(1);
            ev    = EV_DELETE;
          end else begin
            ev = EV_IGNORED;
          end
        end else if ((pkt_i.key_code == KEY_CONFIRM) && (cnt_q == NumDigits)) begin
          cnt_d = '0;
          if (change_q) begin
            stored_pw_d    = packed_i;
            stored_valid_d = 1'b1;
            change_d       = 1'b0;
            unlocked_d     = 1'b1;
            ev             = EV_STORED;
          end else if (ref_pw == packed_i) begin
            unlocked_d = 1'b1;
            ev         = EV_OK;
          end else if (trials_inc >= max_trials_i) begin
            trials_d = '0;
            ev       = EV_LOCKOUT;
          end else begin
            trials_d = trials_inc;
            ev       = EV_WRONG;
          end
        end else begin
          ev = EV_IGNORED;
        end
      end else begin
        ev   = EV_DISPLAY;
        disp = pkt_i.key_code;
      end
    end else if (is_change) begin
      if (unlocked_q) begin
        cnt_d    = '0;
        change_d = 1'b1;
        ev       = EV_CHANGE;
      end else begin
        ev = EV_REFUSED;
      end
    end
  end

  assign buf_wr_o.we    = accept_i && wr_en;
  assign buf_wr_o.idx   = BUF_IDX_W'(cnt_q);
  assign buf_wr_o.digit = pkt_i.key_code[3:0];

  assign res_o.event_res     = ev;
  assign res_o.display_value = disp;
  assign res_o.digit_count   = 3'(cnt_d);
  assign res_o.unlocked      = unlocked_d;
  assign res_o.change_mode   = change_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q          <= '0;
      unlocked_q     <= 1'b0;
      change_q       <= 1'b0;
      trials_q       <= '0;
      stored_valid_q <= 1'b0;
    end else if (accept_i) begin
      cnt_q          <= cnt_d;
      unlocked_q     <= unlocked_d;
      change_q       <= change_d;
      trials_q       <= trials_d;
      stored_valid_q <= stored_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      stored_pw_q <= stored_pw_d;
    end
  end

endmodule

[hw/rtl/keypad_password_lock.sv]
// Keypad password lock. One keypad packet is taken per clock cycle: a packet is
// accepted whenever the result register is empty or its result is taken in the
// same cycle, and its result appears in the result register on the next cycle.
// The packet rate is set by the single decode, edit and six-digit compare path
// that runs from the input channel into the result register. No clearing pass
// follows reset. Configuration writes set the trial limit and the factory
// password and are meant to happen while the lock is idle.
module keypad_password_lock
  import kpl_pkg::*;
#(
  parameter int unsigned PASSWORD_DIGITS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  kpl_key_if.sink               key_i,
  kpl_res_if.source             res_o
);

  logic                 accept;
  logic                 out_valid_q;
  kpl_res_t             out_q;
  kpl_res_t             res;
  kpl_pkt_t             pkt;
  kpl_buf_wr_t          buf_wr;
  logic [4*PASSWORD_DIGITS-1:0] entry_packed;
  logic [TRIAL_W-1:0]   max_trials_q;
  logic [FACTORY_W-1:0] factory_pw_q;

  assign key_i.ready = !out_valid_q || res_o.ready;
  assign accept      = key_i.valid && key_i.ready;

  assign pkt.header     = key_i.header;
  assign pkt.msg_type   = key_i.msg_type;
  assign pkt.msg_length = key_i.msg_length;
  assign pkt.key_code   = key_i.key_code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_trials_q <= MAX_TRIALS_RST;
      factory_pw_q <= FACTORY_PW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_TRIALS: max_trials_q <= cfg_data_i[TRIAL_W-1:0];
        CFG_FACTORY_PW: factory_pw_q <= cfg_data_i[FACTORY_W-1:0];
        default: ;
      endcase
    end
  end

  kpl_ctrl #(
    .PASSWORD_DIGITS(PASSWORD_DIGITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .pkt_i       (pkt),
    .max_trials_i(max_trials_q),
    .factory_pw_i(factory_pw_q),
    .packed_i    (entry_packed),
    .buf_wr_o    (buf_wr),
    .res_o       (res)
  );

  kpl_entry #(
    .PASSWORD_DIGITS(PASSWORD_DIGITS)
  ) u_entry (
    .clk_i   (clk_i),
    .wr_i    (buf_wr),
    .packed_o(entry_packed)
  );

  // result register, refilled on every input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.event_res     = out_q.event_res;
  assign res_o.display_value = out_q.display_value;
  assign res_o.digit_count   = out_q.digit_count;
  assign res_o.unlocked      = out_q.unlocked;
  assign res_o.change_mode   = out_q.change_mode;

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> res_o.valid)
    else $error("input transfer without result");

  a_change_needs_unlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.change_mode) |-> res_o.unlocked)
    else $error("change mode while locked");

  a_display_only_on_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.event_res != EV_DISPLAY)) |-> (res_o.display_value == 8'd0))
    else $error("display value outside display event");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> ((PASSWORD_DIGITS > 7) || (32'(res_o.digit_count) <= PASSWORD_DIGITS)))
    else $error("digit count beyond buffer size");

endmodule

[sim/keypad_password_lock_test.sv]
// testbench of the keypad password lock: directed and random keypad traffic checked against a predictor
`timescale 1ns / 100ps

module keypad_password_lock_test;
  import kpl_pkg::*;

  localparam int PW_DIGITS   = 6;
  localparam int ITEM_TARGET = 650;
  localparam int CYCLE_LIMIT = 200000;
  localparam kpl_pkt_t CHANGE_PKT = '{HDR_VALID, TYPE_CHANGE, LEN_CHANGE, 8'h00};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  kpl_key_if key_if ();
  kpl_res_if res_if ();

  keypad_password_lock #(
    .PASSWORD_DIGITS(PW_DIGITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .key_i      (key_if),
    .res_o      (res_if)
  );

  // lock state as predicted
  logic [3:0]  entry_q [PW_DIGITS];
  int          digit_cnt = 0;
  bit          is_open = 1'b0;
  bit          chg_mode = 1'b0;
  bit          saved_ok = 1'b0;
  logic [3:0]  fail_cnt = '0;
  logic [23:0] saved_pw = '0;
  logic [3:0]  trial_limit = MAX_TRIALS_RST;
  logic [23:0] factory_pw = FACTORY_PW_RST;

  kpl_res_t pending_results[$];
  int       mismatch_cnt = 0;
  int       sent_cnt = 0;
  int       send_calm = 0;
  int       recv_calm = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(8, 40);
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [23:0] entered_code();
    logic [23:0] v;
    v = '0;
    for (int i = 0; i < PW_DIGITS; i++) v = {v[19:0], entry_q[i]};
    return v;
  endfunction

  function automatic kpl_event_e edit_digits(logic [7:0] key, output bit full_confirm);
    full_confirm = 1'b0;
    if (key >= 8'd1 && key <= 8'd9) begin
      if (digit_cnt < PW_DIGITS) begin
        entry_q[digit_cnt] = key[3:0];
        digit_cnt++;
        return EV_DIGIT;
      end
      return EV_IGNORED;
    end
    if (key == KEY_DELETE) begin
      if (digit_cnt > 0) begin
        digit_cnt--;
        return EV_DELETE;
      end
      return EV_IGNORED;
    end
    if (key == KEY_CONFIRM && digit_cnt == PW_DIGITS) full_confirm = 1'b1;
    return EV_IGNORED;
  endfunction

  function automatic kpl_res_t predict_packet(kpl_pkt_t p);
    kpl_res_t    r;
    bit          full_confirm;
    logic [23:0] ref_pw;
    r = '0;
    r.event_res = EV_UNRECOGNIZED;
    if (p.header == HDR_VALID && p.msg_type == TYPE_KEYPAD && p.msg_length == LEN_KEYPAD) begin
      if (chg_mode) begin
        r.event_res = edit_digits(p.key_code, full_confirm);
        if (full_confirm) begin
          saved_pw = entered_code();
          saved_ok = 1'b1;
          digit_cnt = 0;
          chg_mode = 1'b0;
          is_open = 1'b1;
          r.event_res = EV_STORED;
        end
      end else if (is_open) begin
        r.event_res = EV_DISPLAY;
        r.display_value = p.key_code;
      end else begin
        r.event_res = edit_digits(p.key_code, full_confirm);
        if (full_confirm) begin
          ref_pw = saved_ok ? saved_pw : factory_pw;
          digit_cnt = 0;
          if (ref_pw == entered_code()) begin
            is_open = 1'b1;
            r.event_res = EV_OK;
          end else begin
            if (fail_cnt != TRIALS_SAT) fail_cnt = fail_cnt + 1'b1;
            if (fail_cnt >= trial_limit) begin
              fail_cnt = '0;
              r.event_res = EV_LOCKOUT;
            end else begin
              r.event_res = EV_WRONG;
            end
          end
        end
      end
    end else if (p.header == HDR_VALID && p.msg_type == TYPE_CHANGE &&
                 p.msg_length == LEN_CHANGE) begin
      if (is_open) begin
        digit_cnt = 0;
        chg_mode = 1'b1;
        r.event_res = EV_CHANGE;
      end else begin
        r.event_res = EV_REFUSED;
      end
    end
    r.digit_count = 3'(digit_cnt);
    r.unlocked = is_open;
    r.change_mode = chg_mode;
    return r;
  endfunction

  function automatic kpl_pkt_t keypad(logic [7:0] key);
    return '{HDR_VALID, TYPE_KEYPAD, LEN_KEYPAD, key};
  endfunction

  function automatic logic [7:0] odd_key();
    case ($urandom_range(0, 2))
      0: return 8'd0;
      1: return 8'd11;
      default: return 8'($urandom_range(13, 255));
    endcase
  endfunction

  function automatic kpl_pkt_t noise_packet();
    kpl_pkt_t p;
    p.header = $urandom_range(0, 1) ? HDR_VALID : 8'($urandom);
    case ($urandom_range(0, 2))
      0: p.msg_type = TYPE_KEYPAD;
      1: p.msg_type = TYPE_CHANGE;
      default: p.msg_type = 8'($urandom);
    endcase
    case ($urandom_range(0, 2))
      0: p.msg_length = LEN_KEYPAD;
      1: p.msg_length = LEN_CHANGE;
      default: p.msg_length = 8'($urandom);
    endcase
    p.key_code = 8'($urandom);
    return p;
  endfunction

  function automatic logic [23:0] random_code();
    logic [23:0] c;
    c = '0;
    for (int i = 0; i < PW_DIGITS; i++) c = {c[19:0], 4'($urandom_range(1, 9))};
    return c;
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatch_cnt++;
    end
  endfunction

  task automatic send_packet(kpl_pkt_t pkt);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      key_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    key_if.valid      <= 1'b1;
    key_if.header     <= pkt.header;
    key_if.msg_type   <= pkt.msg_type;
    key_if.msg_length <= pkt.msg_length;
    key_if.key_code   <= pkt.key_code;
    do @(posedge clk_i); while (key_if.ready !== 1'b1);
    pending_results.push_back(predict_packet(pkt));
    sent_cnt++;
  endtask

  task automatic wait_idle();
    key_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MAX_TRIALS) trial_limit = data[3:0];
    else factory_pw = data[23:0];
  endtask

  // six digits and a confirm, optionally mixed with edits and stray packets
  task automatic enter_code(logic [23:0] code, bit messy);
    for (int i = PW_DIGITS - 1; i >= 0; i--) begin
      if (messy) begin
        case ($urandom_range(0, 11))
          0: begin
            send_packet(keypad(8'($urandom_range(1, 9))));
            send_packet(keypad(KEY_DELETE));
          end
          1: send_packet(noise_packet());
          2: send_packet(keypad(odd_key()));
          3: send_packet(keypad(KEY_CONFIRM));
          default: ;
        endcase
      end
      send_packet(keypad(8'(code[i*4 +: 4])));
    end
    if (messy && $urandom_range(0, 5) == 0) send_packet(keypad(8'($urandom_range(1, 9))));
    send_packet(keypad(KEY_CONFIRM));
  endtask

  task automatic test_locked_directed();
    send_packet('{8'h55, TYPE_KEYPAD, LEN_KEYPAD, 8'd1});
    send_packet('{HDR_VALID, TYPE_KEYPAD, LEN_CHANGE, 8'd1});
    send_packet('{HDR_VALID, TYPE_CHANGE, LEN_KEYPAD, 8'd0});
    send_packet('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_packet('{8'h00, 8'h00, 8'h00, 8'h00});
    send_packet(CHANGE_PKT);
    send_packet(keypad(8'd0));
    send_packet(keypad(8'd11));
    send_packet(keypad(8'd13));
    send_packet(keypad(8'd255));
    send_packet(keypad(KEY_DELETE));
    send_packet(keypad(KEY_CONFIRM));
    for (int d = 1; d <= PW_DIGITS; d++) send_packet(keypad(8'(d)));
    send_packet(keypad(8'd7));
    send_packet(keypad(KEY_DELETE));
    send_packet(keypad(8'd9));
    send_packet(keypad(KEY_CONFIRM));
  endtask

  task automatic test_lockout_limits();
    write_cfg(CFG_MAX_TRIALS, 24'd1);
    enter_code(random_code(), 1'b0);
    write_cfg(CFG_FACTORY_PW, 24'h000000);
    write_cfg(CFG_MAX_TRIALS, 24'd15);
    repeat (15) enter_code(random_code(), 1'b0);
    write_cfg(CFG_FACTORY_PW, 24'hFFFFFF);
    write_cfg(CFG_MAX_TRIALS, 24'd3);
    repeat (4) enter_code(random_code(), 1'b1);
  endtask

  task automatic test_locked_random();
    repeat (24) begin
      if ($urandom_range(0, 5) == 0) begin
        write_cfg(CFG_MAX_TRIALS, 24'($urandom_range(1, 15)));
        write_cfg(CFG_FACTORY_PW, 24'($urandom));
      end
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 4)) send_packet(noise_packet());
      else enter_code(random_code(), 1'b1);
    end
  endtask

  task automatic test_unlock();
    write_cfg(CFG_FACTORY_PW, 24'h999999);
    write_cfg(CFG_MAX_TRIALS, 24'd15);
    enter_code(24'h999998, 1'b0);
    enter_code(24'h999999, 1'b0);
  endtask

  task automatic test_unlocked_directed();
    send_packet(keypad(8'h00));
    send_packet(keypad(8'hFF));
    send_packet(keypad(KEY_CONFIRM));
    send_packet(keypad(KEY_DELETE));
    send_packet(CHANGE_PKT);
    send_packet(keypad(8'd5));
    send_packet(keypad(8'd5));
    send_packet(CHANGE_PKT);
    send_packet(keypad(8'd0));
    send_packet(keypad(KEY_DELETE));
    send_packet(keypad(KEY_CONFIRM));
    enter_code(24'h111111, 1'b0);
    send_packet(keypad(8'hA5));
  endtask

  task automatic test_unlocked_random();
    while (sent_cnt < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: repeat ($urandom_range(1, 5)) send_packet(keypad(8'($urandom)));
        4, 5, 6, 7: begin
          send_packet(CHANGE_PKT);
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 5)) send_packet(keypad(8'($urandom_range(1, 9))));
            send_packet(CHANGE_PKT);
          end
          enter_code(random_code(), 1'b1);
        end
        8: send_packet(noise_packet());
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            write_cfg(CFG_MAX_TRIALS, 24'($urandom_range(1, 15)));
            write_cfg(CFG_FACTORY_PW, 24'($urandom));
          end else begin
            send_packet(keypad(odd_key()));
          end
        end
      endcase
    end
  endtask

  // result side: random stalls, each transfer checked against the oldest prediction
  initial begin
    kpl_res_t exp_res;
    int       stall;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with no packet outstanding", $time);
        mismatch_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("event_res", 8'(exp_res.event_res), 8'(res_if.event_res));
        check_field("display_value", exp_res.display_value, res_if.display_value);
        check_field("digit_count", 8'(exp_res.digit_count), 8'(res_if.digit_count));
        check_field("unlocked", 8'(exp_res.unlocked), 8'(res_if.unlocked));
        check_field("change_mode", 8'(exp_res.change_mode), 8'(res_if.change_mode));
      end
    end
  end

  initial begin
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= '0;
    cfg_data_i        <= '0;
    key_if.valid      <= 1'b0;
    key_if.header     <= '0;
    key_if.msg_type   <= '0;
    key_if.msg_length <= '0;
    key_if.key_code   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_locked_directed();
    test_lockout_limits();
    test_locked_random();
    test_unlock();
    test_unlocked_directed();
    test_unlocked_random();
    wait_idle();
    if (mismatch_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
hw/rtl/kpl_pkg.sv
hw/rtl/kpl_if.sv
hw/rtl/kpl_entry.sv
hw/rtl/kpl_ctrl.sv
hw/rtl/keypad_password_lock.sv
sim/keypad_password_lock_test.sv
